### rtl/nfam_pkg.sv
// Package for the NFA pattern matcher: item, entry, status and state types,
// operation, kind and register codes. No dependencies.
package nfam_pkg;

    typedef enum logic [1:0] {
        OP_WR_STATE = 2'd0,
        OP_WR_RANGE = 2'd1,
        OP_CODE     = 2'd2,
        OP_END      = 2'd3
    } t_op;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_SPLIT = 2'd1;
    localparam logic [1:0] KIND_EPS   = 2'd2;
    localparam logic [1:0] KIND_MATCH = 2'd3;

    localparam logic CFG_START_STATE = 1'b0;
    localparam logic CFG_RANGE_COUNT = 1'b1;

    localparam int NFA_W   = 24;
    localparam int RANGE_W = 48;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] set;
        logic [7:0] out;
        logic [7:0] alt;
    } t_nfa_entry;

    typedef struct packed {
        logic [5:0]  set;
        logic [20:0] lo;
        logic [20:0] hi;
    } t_range_entry;

    typedef struct packed {
        t_op         op;
        logic [7:0]  index;
        logic [1:0]  entry_kind;
        logic [5:0]  entry_set;
        logic [7:0]  entry_out;
        logic [7:0]  entry_alt;
        logic [20:0] range_low;
        logic [20:0] range_high;
        logic [20:0] code_point;
    } t_item;

    typedef struct packed {
        logic idle;
        logic done;
        logic matched;
    } t_eng_stat;

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b000000000001,
        ST_BEGIN    = 12'b000000000010,
        ST_PREP     = 12'b000000000100,
        ST_CL_POP   = 12'b000000001000,
        ST_CL_RD    = 12'b000000010000,
        ST_CL_EXP   = 12'b000000100000,
        ST_CL_PUSH2 = 12'b000001000000,
        ST_SC_NEXT  = 12'b000010000000,
        ST_SC_CHK   = 12'b000100000000,
        ST_RG_RD    = 12'b001000000000,
        ST_RG_CHK   = 12'b010000000000,
        ST_DONE     = 12'b100000000000
    } t_state;

endpackage

### rtl/nfam_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module nfam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/nfam_engine.sv
// NFA simulation engine: state, range and closure-stack memories and the
// sequencer that walks them. Depends on nfam_pkg and nfam_ram.
module nfam_engine #(
    parameter int MAX_STATES = 256,
    parameter int MAX_RANGES = 256,
    parameter int MAX_SETS   = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_item_acc,
    input  nfam_pkg::t_item    i_item,
    input  logic [7:0]         i_start_state,
    input  logic [8:0]         i_range_count,
    input  logic               i_out_free,
    output nfam_pkg::t_eng_stat o_stat
);
    import nfam_pkg::*;

    localparam int SW  = $clog2(MAX_STATES);
    localparam int SPW = $clog2(MAX_STATES + 1);
    localparam int RW  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int RCW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES + 1) : 1;
    localparam logic [SW-1:0] LAST_STATE = SW'(MAX_STATES - 1);

    t_state r_state, n_state;
    logic [MAX_STATES-1:0] r_active, n_active;
    logic [MAX_STATES-1:0] r_next, n_next;
    logic [MAX_STATES-1:0] r_visited, n_visited;
    logic r_started, n_started;
    logic r_in_begin, n_in_begin;
    logic r_to_next, n_to_next;
    logic r_is_end, n_is_end;
    logic r_hit, n_hit;
    logic [SW-1:0] r_si, n_si;
    logic [RCW-1:0] r_ri, n_ri;
    logic [SPW-1:0] r_sp, n_sp;
    logic [SW-1:0] r_cur, n_cur;
    logic [7:0] r_tgt, n_tgt;
    logic [5:0] r_set, n_set;
    logic [20:0] r_cp, n_cp;

    logic nfa_we;
    logic [SW-1:0] nfa_raddr;
    logic [NFA_W-1:0] nfa_rdata;
    t_nfa_entry nfa_ent, nfa_wr;
    logic rng_we;
    logic [RW-1:0] rng_raddr;
    logic [RANGE_W-1:0] rng_rdata;
    t_range_entry rng_ent, rng_wr;
    logic stk_we;
    logic [SW-1:0] stk_raddr;
    logic [SW-1:0] stk_rdata;
    logic [SPW-1:0] sp_dec;

    logic push_req;
    logic [7:0] push_tgt;
    logic push_ok;
    logic do_step;
    logic ri_ok;
    logic done;

    assign nfa_ent = t_nfa_entry'(nfa_rdata);
    assign rng_ent = t_range_entry'(rng_rdata);
    assign nfa_wr  = '{kind: i_item.entry_kind, set: i_item.entry_set,
                       out: i_item.entry_out, alt: i_item.entry_alt};
    assign rng_wr  = '{set: i_item.entry_set, lo: i_item.range_low,
                       hi: i_item.range_high};
    assign nfa_we  = i_item_acc && (i_item.op == OP_WR_STATE)
                     && (int'(i_item.index) < MAX_STATES);
    assign rng_we  = i_item_acc && (i_item.op == OP_WR_RANGE)
                     && (int'(i_item.index) < MAX_RANGES);
    assign sp_dec  = r_sp - SPW'(1);
    assign stk_raddr = sp_dec[SW-1:0];
    assign ri_ok   = (int'(r_ri) < int'(i_range_count)) && (int'(r_ri) < MAX_RANGES);
    assign rng_raddr = r_ri[RW-1:0];
    // visited is marked on push, so each state enters the stack at most once
    assign push_ok = push_req && (int'(push_tgt) < MAX_STATES)
                     && !r_visited[SW'(push_tgt)];
    assign stk_we  = push_ok;

    nfam_ram #(.WIDTH(NFA_W), .DEPTH(MAX_STATES)) u_nfa (
        .i_clk(i_clk), .i_we(nfa_we), .i_waddr(SW'(i_item.index)),
        .i_wdata(nfa_wr), .i_raddr(nfa_raddr), .o_rdata(nfa_rdata)
    );

    nfam_ram #(.WIDTH(RANGE_W), .DEPTH(MAX_RANGES)) u_rng (
        .i_clk(i_clk), .i_we(rng_we), .i_waddr(RW'(i_item.index)),
        .i_wdata(rng_wr), .i_raddr(rng_raddr), .o_rdata(rng_rdata)
    );

    nfam_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_stk (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(r_sp[SW-1:0]),
        .i_wdata(SW'(push_tgt)), .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_active   = r_active;
        n_next     = r_next;
        n_visited  = r_visited;
        n_started  = r_started;
        n_in_begin = r_in_begin;
        n_to_next  = r_to_next;
        n_is_end   = r_is_end;
        n_hit      = r_hit;
        n_si       = r_si;
        n_ri       = r_ri;
        n_sp       = r_sp;
        n_cur      = r_cur;
        n_tgt      = r_tgt;
        n_set      = r_set;
        n_cp       = r_cp;
        nfa_raddr  = r_si;
        push_req   = 1'b0;
        push_tgt   = r_tgt;
        do_step    = 1'b0;
        done       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_item_acc && (i_item.op == OP_CODE || i_item.op == OP_END)) begin
                    n_is_end = (i_item.op == OP_END);
                    n_cp     = i_item.code_point;
                    if (!r_started) begin
                        n_active   = '0;
                        n_visited  = '0;
                        n_to_next  = 1'b0;
                        n_started  = 1'b1;
                        n_in_begin = 1'b1;
                        n_state    = ST_BEGIN;
                    end else begin
                        n_state = ST_PREP;
                    end
                end
            end
            ST_BEGIN: begin
                push_req = 1'b1;
                push_tgt = i_start_state;
                n_state  = ST_CL_POP;
            end
            ST_PREP: begin
                n_next    = '0;
                n_visited = '0;
                n_to_next = 1'b1;
                n_hit     = 1'b0;
                n_si      = '0;
                n_state   = ST_SC_NEXT;
            end
            ST_CL_POP: begin
                if (r_sp == '0) begin
                    if (r_in_begin) begin
                        n_in_begin = 1'b0;
                        n_state    = ST_PREP;
                    end else begin
                        do_step = 1'b1;
                    end
                end else begin
                    n_sp    = sp_dec;
                    n_state = ST_CL_RD;
                end
            end
            ST_CL_RD: begin
                n_cur     = stk_rdata;
                nfa_raddr = stk_rdata;
                n_state   = ST_CL_EXP;
            end
            ST_CL_EXP: begin
                n_state = ST_CL_POP;
                if (nfa_ent.kind == KIND_SPLIT) begin
                    push_req = 1'b1;
                    push_tgt = nfa_ent.alt;
                    n_tgt    = nfa_ent.out;
                    n_state  = ST_CL_PUSH2;
                end else if (nfa_ent.kind == KIND_EPS) begin
                    push_req = 1'b1;
                    push_tgt = nfa_ent.out;
                end else if (r_to_next) begin
                    n_next[r_cur] = 1'b1;
                end else begin
                    n_active[r_cur] = 1'b1;
                end
            end
            ST_CL_PUSH2: begin
                push_req = 1'b1;
                push_tgt = r_tgt;
                n_state  = ST_CL_POP;
            end
            ST_SC_NEXT: begin
                if (r_active[r_si]) begin
                    n_state = ST_SC_CHK;
                end else begin
                    do_step = 1'b1;
                end
            end
            ST_SC_CHK: begin
                if (r_is_end) begin
                    if (nfa_ent.kind == KIND_MATCH) begin
                        n_hit = 1'b1;
                    end
                    do_step = 1'b1;
                end else if (nfa_ent.kind == KIND_CHAR && int'(nfa_ent.set) < MAX_SETS) begin
                    n_set   = nfa_ent.set;
                    n_tgt   = nfa_ent.out;
                    n_ri    = '0;
                    n_state = ST_RG_RD;
                end else begin
                    do_step = 1'b1;
                end
            end
            ST_RG_RD: begin
                if (ri_ok) begin
                    n_state = ST_RG_CHK;
                end else begin
                    do_step = 1'b1;
                end
            end
            ST_RG_CHK: begin
                if (rng_ent.set == r_set && rng_ent.lo <= r_cp && r_cp <= rng_ent.hi) begin
                    push_req = 1'b1;
                    n_state  = ST_CL_POP;
                end else begin
                    n_ri    = r_ri + RCW'(1);
                    n_state = ST_RG_RD;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    done      = 1'b1;
                    n_active  = '0;
                    n_started = 1'b0;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (push_ok) begin
            n_visited[SW'(push_tgt)] = 1'b1;
            n_sp = r_sp + SPW'(1);
        end

        if (do_step) begin
            if (r_si == LAST_STATE) begin
                if (r_is_end) begin
                    n_state = ST_DONE;
                end else begin
                    n_active = r_next;
                    n_state  = ST_IDLE;
                end
            end else begin
                n_si    = r_si + SW'(1);
                n_state = ST_SC_NEXT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_active   <= '0;
            r_next     <= '0;
            r_visited  <= '0;
            r_started  <= 1'b0;
            r_in_begin <= 1'b0;
            r_to_next  <= 1'b0;
            r_is_end   <= 1'b0;
            r_hit      <= 1'b0;
            r_si       <= '0;
            r_ri       <= '0;
            r_sp       <= '0;
        end else begin
            r_state    <= n_state;
            r_active   <= n_active;
            r_next     <= n_next;
            r_visited  <= n_visited;
            r_started  <= n_started;
            r_in_begin <= n_in_begin;
            r_to_next  <= n_to_next;
            r_is_end   <= n_is_end;
            r_hit      <= n_hit;
            r_si       <= n_si;
            r_ri       <= n_ri;
            r_sp       <= n_sp;
        end
        r_cur <= n_cur;
        r_tgt <= n_tgt;
        r_set <= n_set;
        r_cp  <= n_cp;
    end

    assign o_stat = '{idle: (r_state == ST_IDLE), done: done, matched: r_hit};
endmodule

### rtl/nfa_pattern_matcher.sv
// Top level of the NFA pattern matcher: stream ports, configuration
// registers and output register. Depends on nfam_pkg and nfam_engine.
//
//  channel   | direction | transaction
//  s_axis    | in        | load entry, code point or end of text (op in tuser)
//  m_axis    | out       | matched flag, one per end of text
//  cfg       | in        | write start_state (0) or range_count (1)
//
// Load transactions are taken while the engine is idle. A code point costs a scan
// over all MAX_STATES states, plus a check per range entry scanned for each active
// character state, plus a closure walk per state entered; the single read port of
// the state memory and the range memory scan set this. Reset needs no clearing pass.
// A stalled result blocks new items only once the next end of text is processed.
module nfa_pattern_matcher #(
    parameter int MAX_STATES = 256,
    parameter int MAX_RANGES = 256,
    parameter int MAX_SETS   = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // index[7:0] entry_kind[9:8] entry_set[15:10] entry_out[23:16] entry_alt[31:24]
    // range_low[52:32] range_high[73:53] code_point[94:74], zero above
    input  logic [95:0]  i_s_axis_tdata,
    // op[1:0]
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // matched[0], zero above
    output logic [7:0]   o_m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic         i_cfg_addr,
    input  logic [8:0]   i_cfg_wdata
);
    import nfam_pkg::*;

    logic [7:0] r_start_state;
    logic [8:0] r_range_count;
    logic r_m_valid;
    logic r_matched;
    t_item item;
    t_eng_stat stat;
    logic item_acc;
    logic out_free;

    assign item = '{op: t_op'(i_s_axis_tuser), index: i_s_axis_tdata[7:0],
                    entry_kind: i_s_axis_tdata[9:8], entry_set: i_s_axis_tdata[15:10],
                    entry_out: i_s_axis_tdata[23:16], entry_alt: i_s_axis_tdata[31:24],
                    range_low: i_s_axis_tdata[52:32], range_high: i_s_axis_tdata[73:53],
                    code_point: i_s_axis_tdata[94:74]};
    assign o_s_axis_tready = stat.idle;
    assign item_acc = i_s_axis_tvalid && stat.idle;
    assign out_free = !r_m_valid || i_m_axis_tready;

    nfam_engine #(
        .MAX_STATES(MAX_STATES), .MAX_RANGES(MAX_RANGES), .MAX_SETS(MAX_SETS)
    ) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item_acc(item_acc), .i_item(item),
        .i_start_state(r_start_state), .i_range_count(r_range_count),
        .i_out_free(out_free), .o_stat(stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_state <= '0;
            r_range_count <= '0;
            r_m_valid     <= 1'b0;
            r_matched     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_START_STATE: r_start_state <= i_cfg_wdata[7:0];
                    CFG_RANGE_COUNT: r_range_count <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (stat.done) begin
                r_m_valid <= 1'b1;
                r_matched <= stat.matched;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {7'd0, r_matched};
endmodule

### rtl/nfam_checker.sv
// Port-level checker for the NFA pattern matcher, bound to the top level.
// No dependencies.
module nfam_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [1:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata
);
    // a result waiting downstream is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result right after reset");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[7:1] == 7'd0))
        else $error("nonzero result padding");

    // ready is low in the cycle after a text item is taken
    a_text_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser[1] |=> !o_s_axis_tready)
        else $error("ready right after text transaction");
endmodule

bind nfa_pattern_matcher nfam_checker u_nfam_checker (.*);

### test/nfa_pattern_matcher_tb.sv
// Testbench for nfa_pattern_matcher: loads NFA and range tables, streams texts,
// checks each matched flag against a behavioral predictor. Depends on nfam_pkg.
`timescale 1ns / 100ps

module nfa_pattern_matcher_tb;
    import nfam_pkg::*;

    localparam int N_STATES  = 256;
    localparam int N_RANGES  = 256;
    localparam int CYC_LIMIT = 6000000;
    localparam int N_RANDOM  = 900;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [95:0]  i_s_axis_tdata;
    logic [1:0]   i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [7:0]   o_m_axis_tdata;
    logic         i_cfg_we;
    logic         i_cfg_addr;
    logic [8:0]   i_cfg_wdata;

    nfa_pattern_matcher dut (.*);

    // predictor copy of the block
    t_nfa_entry   nfa_mem [N_STATES];
    t_range_entry rng_mem [N_RANGES];
    bit           live [N_STATES];
    bit           in_text;
    logic [7:0]   start_reg;
    logic [8:0]   rcount_reg;

    bit           matched_q [$];
    int           fails;
    int           sent;
    int           cyc;
    bit           calm;

    typedef struct {
        t_op         op;
        logic [7:0]  idx;
        logic [1:0]  kind;
        logic [5:0]  set;
        logic [7:0]  nxt;
        logic [7:0]  alt;
        logic [20:0] lo;
        logic [20:0] hi;
        logic [20:0] cp;
        bit          typed;
        bit          want;
    } t_row;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // epsilon closure of one state, marks reached char/match states in dest
    task automatic close_over(input logic [7:0] root, ref bit dest [N_STATES],
                              ref bit seen [N_STATES]);
        logic [7:0] stk [$];
        logic [7:0] cur;
        stk.push_back(root);
        while (stk.size() > 0) begin
            cur = stk.pop_back();
            if (seen[cur]) continue;
            seen[cur] = 1'b1;
            if (nfa_mem[cur].kind == KIND_SPLIT) begin
                stk.push_back(nfa_mem[cur].alt);
                stk.push_back(nfa_mem[cur].out);
            end else if (nfa_mem[cur].kind == KIND_EPS) begin
                stk.push_back(nfa_mem[cur].out);
            end else begin
                dest[cur] = 1'b1;
            end
        end
    endtask

    function automatic bit set_hit(logic [5:0] set, logic [20:0] cp);
        int n;
        n = (rcount_reg < N_RANGES) ? rcount_reg : N_RANGES;
        for (int i = 0; i < n; i++)
            if (rng_mem[i].set == set && rng_mem[i].lo <= cp && cp <= rng_mem[i].hi)
                return 1'b1;
        return 1'b0;
    endfunction

    task automatic predict_item(input t_row r);
        bit seen [N_STATES];
        bit nxt [N_STATES];
        bit known [64];
        bit member [64];
        bit hit;
        logic [5:0] st;
        hit = 1'b0;
        case (r.op)
            OP_WR_STATE: nfa_mem[r.idx] = '{r.kind, r.set, r.nxt, r.alt};
            OP_WR_RANGE: rng_mem[r.idx] = '{r.set, r.lo, r.hi};
            default: begin
                if (!in_text) begin
                    live = '{default: 0};
                    seen = '{default: 0};
                    close_over(start_reg, live, seen);
                    in_text = 1'b1;
                end
                if (r.op == OP_CODE) begin
                    nxt = '{default: 0};
                    seen = '{default: 0};
                    known = '{default: 0};
                    for (int s = 0; s < N_STATES; s++) begin
                        if (!live[s] || nfa_mem[s].kind != KIND_CHAR) continue;
                        st = nfa_mem[s].set;
                        if (!known[st]) begin
                            known[st] = 1'b1;
                            member[st] = set_hit(st, r.cp);
                        end
                        if (member[st]) close_over(nfa_mem[s].out, nxt, seen);
                    end
                    live = nxt;
                end else begin
                    for (int s = 0; s < N_STATES; s++)
                        if (live[s] && nfa_mem[s].kind == KIND_MATCH) hit = 1'b1;
                    matched_q.push_back(hit);
                    live = '{default: 0};
                    in_text = 1'b0;
                end
            end
        endcase
    endtask

    // one transaction on the input stream; called right after the clock rises
    task automatic push_item(input t_row r);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= r.op;
        i_s_axis_tdata  <= {1'b0, r.cp, r.hi, r.lo, r.alt, r.nxt, r.set, r.kind, r.idx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_item(r);
        if (r.typed && matched_q[$] != r.want) begin
            $error("typed row: matched expected %0d, predicted %0d", r.want, matched_q[$]);
            fails++;
        end
        sent++;
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (matched_q.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic addr, input logic [8:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (addr == CFG_START_STATE) start_reg = val[7:0];
        else rcount_reg = val;
    endtask

    function automatic t_row mk(t_op op, logic [7:0] idx, logic [1:0] kind, logic [5:0] set,
                                logic [7:0] nxt, logic [7:0] alt, logic [20:0] lo,
                                logic [20:0] hi, logic [20:0] cp);
        mk = '{op, idx, kind, set, nxt, alt, lo, hi, cp, 1'b0, 1'b0};
    endfunction

    function automatic t_row fin(bit typed, bit want);
        fin = mk(OP_END, 8'($urandom), 2'($urandom), 6'($urandom), 8'($urandom),
                 8'($urandom), 21'($urandom), 21'($urandom), 21'($urandom));
        fin.typed = typed;
        fin.want  = want;
    endfunction

    function automatic t_row chr(logic [20:0] cp);
        chr = mk(OP_CODE, 8'($urandom), 2'($urandom), 6'($urandom), 8'($urandom),
                 8'($urandom), 21'($urandom), 21'($urandom), cp);
    endfunction

    function automatic logic [20:0] pick_cp(bit wide);
        if (wide || $urandom_range(0, 9) == 0) return 21'($urandom_range(0, 1114111));
        return 21'($urandom_range(0, 31));
    endfunction

    // result side: random stall per transaction, checks against oldest expectation
    initial begin
        int stall;
        i_m_axis_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            if (matched_q.size() == 0) begin
                $error("unexpected result transaction, matched %0d", o_m_axis_tdata[0]);
                fails++;
            end else begin
                if (o_m_axis_tdata[0] !== matched_q[0]) begin
                    $error("matched: expected %0d, actual %0d",
                           matched_q[0], o_m_axis_tdata[0]);
                    fails++;
                end
                if (o_m_axis_tdata[7:1] !== 7'd0) begin
                    $error("tdata pad: expected 0, actual %0h", o_m_axis_tdata[7:1]);
                    fails++;
                end
                void'(matched_q.pop_front());
            end
        end
    end

    initial begin
        t_row dir [$];
        int base, rc, nr, ntext, nch;
        bit wide, full_set;
        fails = 0; sent = 0; cyc = 0; calm = 1'b0;
        in_text = 1'b0; start_reg = '0; rcount_reg = '0;
        live = '{default: 0};
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = OP_WR_STATE;
        i_cfg_we = 1'b0;
        i_cfg_addr = CFG_START_STATE;
        i_cfg_wdata = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill both tables so no closure or range scan touches an unwritten entry
        calm = 1'b1;
        for (int i = 0; i < N_STATES; i++)
            push_item(mk(OP_WR_STATE, 8'(i), KIND_MATCH, 6'($urandom), 8'($urandom),
                         8'($urandom), 21'($urandom), 21'($urandom), 21'($urandom)));
        for (int i = 0; i < N_RANGES; i++)
            push_item(mk(OP_WR_RANGE, 8'(i), 2'($urandom), 6'($urandom), 8'($urandom),
                         8'($urandom), 21'($urandom_range(0, 1114111)),
                         21'($urandom_range(0, 1114111)), 21'($urandom)));
        drain();
        calm = 1'b0;
        write_reg(CFG_START_STATE, 9'd0);
        write_reg(CFG_RANGE_COUNT, 9'd2);

        // a(b|c)* : 0 char{1}->1, 1 split 2|3, 2 char{2}->1, 3 eps->4, 4 match
        dir.push_back(fin(1'b1, 1'b1));                  // empty text, start is match
        dir.push_back(mk(OP_WR_STATE, 8'd0, KIND_CHAR, 6'd1, 8'd1, 8'd0, 0, 0, 0));
        dir.push_back(mk(OP_WR_STATE, 8'd1, KIND_SPLIT, 6'd0, 8'd2, 8'd3, 0, 0, 0));
        dir.push_back(mk(OP_WR_STATE, 8'd2, KIND_CHAR, 6'd2, 8'd1, 8'd0, 0, 0, 0));
        dir.push_back(mk(OP_WR_STATE, 8'd3, KIND_EPS, 6'd0, 8'd4, 8'd0, 0, 0, 0));
        dir.push_back(mk(OP_WR_STATE, 8'd4, KIND_MATCH, 6'd0, 8'd0, 8'd0, 0, 0, 0));
        dir.push_back(mk(OP_WR_STATE, 8'd255, KIND_MATCH, 6'd63, 8'd255, 8'd255, 0, 0, 0));
        dir.push_back(mk(OP_WR_RANGE, 8'd0, 2'd0, 6'd1, 8'd0, 8'd0, 21'd97, 21'd97, 0));
        dir.push_back(mk(OP_WR_RANGE, 8'd1, 2'd0, 6'd2, 8'd0, 8'd0, 21'd98, 21'd99, 0));
        dir.push_back(mk(OP_WR_RANGE, 8'd255, 2'd3, 6'd63, 8'd255, 8'd255,
                         21'd0, 21'd1114111, 21'd0));
        dir.push_back(fin(1'b1, 1'b0));                  // empty text, start is char
        dir.push_back(chr(21'd97));
        dir.push_back(fin(1'b1, 1'b1));
        dir.push_back(chr(21'd97));
        dir.push_back(chr(21'd98));
        dir.push_back(chr(21'd99));
        dir.push_back(fin(1'b1, 1'b1));
        dir.push_back(chr(21'd98));                      // set dies at once
        dir.push_back(fin(1'b1, 1'b0));
        dir.push_back(chr(21'd97));
        dir.push_back(chr(21'd1114111));                 // dead, stays dead
        dir.push_back(chr(21'd98));
        dir.push_back(fin(1'b1, 1'b0));
        dir.push_back(chr(21'd0));
        dir.push_back(fin(1'b1, 1'b0));
        foreach (dir[i]) push_item(dir[i]);
        drain();

        write_reg(CFG_RANGE_COUNT, 9'd256);              // top entry covers everything
        write_reg(CFG_START_STATE, 9'd255);
        push_item(chr(21'd5));
        push_item(fin(1'b0, 1'b0));
        drain();

        sent = 0;
        while (sent < N_RANDOM) begin
            base = $urandom_range(0, 255);
            wide = ($urandom_range(0, 3) == 0);
            full_set = ($urandom_range(0, 5) == 0);
            calm = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 11))
                0:       rc = 0;
                1:       rc = 256;
                2:       rc = 257 + $urandom_range(0, 254);
                default: rc = $urandom_range(1, 8);
            endcase
            for (int k = 0; k < 8; k++)
                push_item(mk(OP_WR_STATE, 8'(base + k),
                             ($urandom_range(0, 2) == 0) ? 2'($urandom) : KIND_CHAR,
                             full_set ? 6'($urandom) : 6'($urandom_range(0, 7)),
                             ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                         : 8'(base + $urandom_range(0, 7)),
                             ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                         : 8'(base + $urandom_range(0, 7)),
                             0, 0, 21'($urandom)));
            nr = (rc < 8) ? rc : 8;
            for (int k = 0; k < nr; k++)
                push_item(mk(OP_WR_RANGE, 8'(k), 2'($urandom),
                             full_set ? 6'($urandom) : 6'($urandom_range(0, 7)),
                             8'($urandom), 8'($urandom),
                             pick_cp(wide) & 21'h1FFFF0, pick_cp(wide) | 21'h00000F,
                             21'($urandom)));
            drain();
            write_reg(CFG_START_STATE, ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 255))
                                                                   : 9'(8'(base)));
            write_reg(CFG_RANGE_COUNT, 9'(rc));
            ntext = $urandom_range(3, 6);
            for (int t = 0; t < ntext; t++) begin
                nch = $urandom_range(0, 6);
                for (int c = 0; c < nch; c++) begin
                    if ($urandom_range(0, 19) == 0)
                        push_item(mk(OP_WR_STATE, 8'($urandom), 2'($urandom), 6'($urandom),
                                     8'($urandom), 8'($urandom), 0, 0, 0));
                    else if ($urandom_range(0, 19) == 0)
                        push_item(mk(OP_WR_RANGE, 8'($urandom), 2'($urandom), 6'($urandom),
                                     8'($urandom), 8'($urandom),
                                     21'($urandom_range(0, 1114111)),
                                     21'($urandom_range(0, 1114111)), 0));
                    push_item(chr(pick_cp(wide)));
                end
                push_item(fin(1'b0, 1'b0));
            end
            drain();
        end

        i_s_axis_tvalid <= 1'b0;
        while (matched_q.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### nfa_pattern_matcher.f
rtl/nfam_pkg.sv
rtl/nfam_ram.sv
rtl/nfam_engine.sv
rtl/nfa_pattern_matcher.sv
rtl/nfam_checker.sv
test/nfa_pattern_matcher_tb.sv
